### src/chmp_pkg.sv
// Shared types and constants for the coin heads majority probability unit.
// No dependencies; chmp_mac and the top level refer to it by scoped names.
`default_nettype none

package chmp_pkg;

  // Sizing
  localparam int MAX_COINS      = 64;
  localparam int PROB_FRAC_BITS = 16;
  localparam int PROB_W         = 17;
  localparam int DIST_W         = 33;
  localparam int SEEN_W         = 7;
  localparam int DIST_DEPTH     = MAX_COINS + 1;
  localparam int ADDR_W         = $clog2(DIST_DEPTH);
  localparam int CNT_W          = $clog2(MAX_COINS + 2);
  localparam int ACC_W          = DIST_W + $clog2(MAX_COINS + 2);
  localparam int PROD_W         = DIST_W + PROB_W;

  // Fixed-point one in each format
  localparam logic [PROB_W-1:0] ONE_PROB = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [DIST_W-1:0] ONE_DIST = DIST_W'(1) << (DIST_W - 1);

  // Input word: one coin
  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              last;
  } item_t;

  // Output word: one closed set
  typedef struct packed {
    logic [DIST_W-1:0] tail_prob;
    logic [SEEN_W-1:0] coins_seen;
    logic              too_many;
  } result_t;

endpackage

`default_nettype wire

### src/chmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module chmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/chmp_mac.sv
// Shared multiply-add unit: trunc(a*q) + trunc(b*p), saturated to one.
// Products are registered; the add and clamp follow the register. Uses chmp_pkg.
`default_nettype none

module chmp_mac (
  input  wire logic                         clk,
  input  wire logic [chmp_pkg::DIST_W-1:0]  a,
  input  wire logic [chmp_pkg::DIST_W-1:0]  b,
  input  wire logic [chmp_pkg::PROB_W-1:0]  p,
  input  wire logic [chmp_pkg::PROB_W-1:0]  q,
  output logic      [chmp_pkg::DIST_W-1:0]  val
);

  logic [chmp_pkg::PROD_W-1:0] prod_q;
  logic [chmp_pkg::PROD_W-1:0] prod_p;
  logic [chmp_pkg::DIST_W-1:0] scaled_q;
  logic [chmp_pkg::DIST_W-1:0] scaled_p;
  logic [chmp_pkg::DIST_W:0]   total;

  // Multiply at full width
  assign prod_q = chmp_pkg::PROD_W'(a) * chmp_pkg::PROD_W'(q);
  assign prod_p = chmp_pkg::PROD_W'(b) * chmp_pkg::PROD_W'(p);

  // Drop fraction bits and hold the scaled products
  always_ff @(posedge clk) begin
    scaled_q <= chmp_pkg::DIST_W'(prod_q >> chmp_pkg::PROB_FRAC_BITS);
    scaled_p <= chmp_pkg::DIST_W'(prod_p >> chmp_pkg::PROB_FRAC_BITS);
  end

  // Add and clamp to one
  assign total = {1'b0, scaled_q} + {1'b0, scaled_p};
  assign val   = (total > {1'b0, chmp_pkg::ONE_DIST}) ? chmp_pkg::ONE_DIST
                                                      : total[chmp_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

### src/coin_heads_majority_probability_unit.sv
// Top level: sequencer, head-count distribution store and the shared multiply-add.
// Depends on chmp_pkg, chmp_ram and chmp_mac.
`default_nettype none

// Each accepted word is one coin with its heads probability. A coin with n coins
// already in the set keeps busy high while the single multiply-add unit updates
// one head-count entry per cycle, from the top count down, through the store's
// one read and one write port, plus the pipeline fill and a closing step. A coin
// that arrives when the store is full is dropped and flags the set; without the
// last mark busy never rises for it, with it the store is walked once to form
// the sum. On the last coin of a set the result word appears for exactly one
// cycle with result_valid high, and the block starts a fresh set. The receiver
// cannot stall: capture it on that cycle.
module coin_heads_majority_probability_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire chmp_pkg::item_t   item,
  output logic                   result_valid,
  output chmp_pkg::result_t      result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t                        state;
  logic [chmp_pkg::CNT_W-1:0]    coin_count;
  logic                          overflow_seen;
  logic                          last_flag;
  logic                          sum_mode;
  logic [chmp_pkg::PROB_W-1:0]   p_reg;
  logic [chmp_pkg::PROB_W-1:0]   q_reg;
  logic [chmp_pkg::CNT_W-1:0]    n_reg;
  logic [chmp_pkg::CNT_W-1:0]    thr;
  logic [chmp_pkg::CNT_W-1:0]    step;
  logic                          issue_done;
  logic                          s1_valid;
  logic                          s1_zero;
  logic [chmp_pkg::CNT_W-1:0]    s1_idx;
  logic                          s2_valid;
  logic [chmp_pkg::CNT_W-1:0]    s2_idx;
  logic [chmp_pkg::DIST_W-1:0]   a_reg;
  logic [chmp_pkg::ACC_W-1:0]    acc;

  logic [chmp_pkg::PROB_W-1:0]   p_sat;
  logic                          accept;
  logic                          store_full;
  logic                          issuing;
  logic [chmp_pkg::CNT_W-1:0]    rd_idx;
  logic [chmp_pkg::DIST_W-1:0]   rd_data;
  logic [chmp_pkg::DIST_W-1:0]   b_val;
  logic [chmp_pkg::DIST_W-1:0]   mac_val;
  logic                          wr_en;
  logic [chmp_pkg::CNT_W-1:0]    n_plus;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign store_full = (coin_count >= chmp_pkg::CNT_W'(chmp_pkg::MAX_COINS));
  assign p_sat      = (item.prob > chmp_pkg::ONE_PROB) ? chmp_pkg::ONE_PROB : item.prob;
  assign n_plus     = n_reg + chmp_pkg::CNT_W'(1);

  // Issue one read per step, top entry first
  assign issuing = (state == ST_RUN) && !issue_done;
  assign rd_idx  = n_reg - step;

  // Operand from the store; a fresh set has entry zero at one
  always_comb begin
    if (s1_zero) begin
      b_val = '0;
    end else if (n_reg == '0) begin
      b_val = chmp_pkg::ONE_DIST;
    end else begin
      b_val = rd_data;
    end
  end

  assign wr_en = s2_valid && !sum_mode;

  chmp_ram #(
    .WIDTH (chmp_pkg::DIST_W),
    .DEPTH (chmp_pkg::DIST_DEPTH)
  ) u_dist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (chmp_pkg::ADDR_W'(s2_idx)),
    .wdata (mac_val),
    .raddr (chmp_pkg::ADDR_W'(rd_idx)),
    .rdata (rd_data)
  );

  chmp_mac u_mac (
    .clk (clk),
    .a   (a_reg),
    .b   (b_val),
    .p   (p_reg),
    .q   (q_reg),
    .val (mac_val)
  );

  // Sequencer, pipeline tags, accumulator and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      coin_count    <= '0;
      overflow_seen <= 1'b0;
      issue_done    <= 1'b1;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_flag  <= item.last;
            n_reg      <= coin_count;
            step       <= '0;
            issue_done <= 1'b0;
            a_reg      <= '0;
            acc        <= '0;
            if (store_full) begin
              // Drop the coin; walk the store only to close the set
              overflow_seen <= 1'b1;
              sum_mode      <= 1'b1;
              p_reg         <= chmp_pkg::ONE_PROB;
              q_reg         <= '0;
              thr           <= (coin_count >> 1) + chmp_pkg::CNT_W'(1);
              if (item.last) begin
                state <= ST_RUN;
              end else begin
                issue_done <= 1'b1;
              end
            end else begin
              sum_mode <= 1'b0;
              p_reg    <= p_sat;
              q_reg    <= chmp_pkg::ONE_PROB - p_sat;
              thr      <= (coin_count + chmp_pkg::CNT_W'(1)) >> 1;
              state    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Read stage
          s1_valid <= issuing;
          if (issuing) begin
            s1_idx  <= n_plus - step;
            s1_zero <= (step == n_plus);
            step    <= step + chmp_pkg::CNT_W'(1);
            if (step == n_plus) begin
              issue_done <= 1'b1;
            end
          end
          // Multiply stage: shift the operand pair down one entry
          s2_valid <= s1_valid;
          if (s1_valid) begin
            s2_idx <= s1_idx;
            a_reg  <= b_val;
          end
          // Write stage: accumulate the upper tail
          if (s2_valid) begin
            if (s2_idx > thr) begin
              acc <= acc + chmp_pkg::ACC_W'(mac_val);
            end
            if (s2_idx == '0) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (last_flag) begin
            result_valid      <= 1'b1;
            result.tail_prob  <= (acc > chmp_pkg::ACC_W'(chmp_pkg::ONE_DIST))
                                 ? chmp_pkg::ONE_DIST : acc[chmp_pkg::DIST_W-1:0];
            result.coins_seen <= sum_mode ? chmp_pkg::SEEN_W'(n_reg)
                                          : chmp_pkg::SEEN_W'(n_plus);
            result.too_many   <= overflow_seen;
            coin_count        <= '0;
            overflow_seen     <= 1'b0;
          end else begin
            coin_count <= n_plus;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/coin_heads_majority_probability_unit_tb.sv
// Self-checking testbench for coin_heads_majority_probability_unit.
// Depends on chmp_pkg and the unit under test; needs no files or arguments.
`timescale 1ns / 100ps

module coin_heads_majority_probability_unit_tb;
  import chmp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_COINS = 490;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_ROWS     = 18;
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
  localparam logic [32:0] TAIL_ONE = 33'h1_0000_0000;

  // One row of the directed table: a coin repeated reps times, with the
  // result word typed in where it is obvious
  typedef struct {
    logic [PROB_W-1:0] prob;
    logic              last;
    int                reps;
    bit                fixed;
    logic [DIST_W-1:0] tail;
    logic [SEEN_W-1:0] seen;
    logic              tm;
  } coin_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    result_valid;
  result_t result;

  // Predictor state: head-count distribution of the open set
  logic [63:0] dist_q [0:MAX_COINS];
  int          coin_cnt;
  bit          ovf_flag;

  result_t     expected_sets [$];
  int          mismatches;
  int          cycles;
  bit          no_idle;

  coin_row_t dir_rows [NUM_ROWS] = '{
    // single sure coin, single impossible coin, probability above one
    '{17'd65536,  1'b1, 1,  1'b1, TAIL_ONE, 7'd1,  1'b0},
    '{17'd0,      1'b1, 1,  1'b1, 33'd0,    7'd1,  1'b0},
    '{17'd131071, 1'b1, 1,  1'b1, TAIL_ONE, 7'd1,  1'b0},
    // two sure coins
    '{17'd65536,  1'b0, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd65536,  1'b1, 1,  1'b1, TAIL_ONE, 7'd2,  1'b0},
    // near one then near zero
    '{17'd65535,  1'b0, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd1,      1'b1, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    // four fair coins
    '{17'd32768,  1'b0, 3,  1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd32768,  1'b1, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    // full store of sure coins, last mark on a dropped coin closes the set
    '{17'd65536,  1'b0, 64, 1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd0,      1'b1, 1,  1'b1, TAIL_ONE, 7'd64, 1'b1},
    // full store of impossible coins, a dropped coin without last, then close
    '{17'd0,      1'b0, 64, 1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd65536,  1'b0, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    '{17'd131071, 1'b1, 1,  1'b1, 33'd0,    7'd64, 1'b1},
    // alternating bit patterns
    '{17'h15555,  1'b0, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    '{17'h0AAAA,  1'b1, 1,  1'b0, 33'd0,    7'd0,  1'b0},
    // exactly full store, no overflow
    '{17'h0AAAA,  1'b0, 63, 1'b0, 33'd0,    7'd0,  1'b0},
    '{17'h05555,  1'b1, 1,  1'b0, 33'd0,    7'd0,  1'b0}
  };

  coin_heads_majority_probability_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  // Free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] scale_by(logic [63:0] v, logic [63:0] f);
    return (v * f) >> PROB_FRAC_BITS;
  endfunction

  function automatic logic [63:0] clamp_one(logic [63:0] v);
    return (v > ONE_Q32) ? ONE_Q32 : v;
  endfunction

  // Start a fresh set: all mass on zero heads
  function void clear_dist();
    foreach (dist_q[j]) dist_q[j] = 64'd0;
    dist_q[0] = ONE_Q32;
    coin_cnt  = 0;
    ovf_flag  = 1'b0;
  endfunction

  // Fold one coin into the distribution; close the set on last
  task automatic predict_coin(input logic [PROB_W-1:0] coin_prob, input logic coin_last,
                              output bit has_res, output result_t res);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] acc;
    int          n;
    p       = (coin_prob > ONE_PROB) ? 64'(ONE_PROB) : 64'(coin_prob);
    q       = (64'd1 << PROB_FRAC_BITS) - p;
    has_res = 1'b0;
    res     = '0;
    if (coin_cnt >= MAX_COINS) begin
      ovf_flag = 1'b1;
    end else begin
      n = coin_cnt;
      dist_q[n + 1] = clamp_one(scale_by(dist_q[n], p));
      for (int j = n; j > 0; j--)
        dist_q[j] = clamp_one(scale_by(dist_q[j], q) + scale_by(dist_q[j - 1], p));
      dist_q[0] = clamp_one(scale_by(dist_q[0], q));
      coin_cnt  = n + 1;
    end
    if (coin_last) begin
      acc = 64'd0;
      for (int j = coin_cnt / 2 + 1; j <= coin_cnt; j++)
        acc += dist_q[j];
      acc            = clamp_one(acc);
      res.tail_prob  = acc[DIST_W-1:0];
      res.coins_seen = coin_cnt[SEEN_W-1:0];
      res.too_many   = ovf_flag;
      has_res        = 1'b1;
      clear_dist();
    end
  endtask

  // Mostly back-to-back or short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Weight the extremes and the saturation range
  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'($urandom_range(32000, 33536));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Offer one coin word, hold it until accepted, then record the expectation
  task automatic send_coin(input logic [PROB_W-1:0] coin_prob, input logic coin_last,
                           input bit fixed, input result_t want);
    int      gap;
    bit      has_res;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    item.prob <= coin_prob;
    item.last <= coin_last;
    do @(posedge clk); while (busy);
    predict_coin(coin_prob, coin_last, has_res, pred);
    if (has_res) expected_sets.push_back(fixed ? want : pred);
  endtask

  // Stimulus: directed table, then random sets
  initial begin
    result_t row_want;
    result_t none;
    int      coins;
    int      set_len;
    int      r;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    none       = '0;
    clear_dist();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row_want.tail_prob  = dir_rows[i].tail;
      row_want.coins_seen = dir_rows[i].seen;
      row_want.too_many   = dir_rows[i].tm;
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_coin(dir_rows[i].prob, dir_rows[i].last, dir_rows[i].fixed, row_want);
    end

    // Random sets: mostly small, some large, a few past capacity
    coins = 0;
    while (coins < RANDOM_COINS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      set_len = $urandom_range(1, 6);
      else if (r < 92) set_len = $urandom_range(7, 40);
      else if (r < 97) set_len = $urandom_range(41, MAX_COINS);
      else             set_len = $urandom_range(MAX_COINS + 1, MAX_COINS + 8);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++)
        send_coin(pick_prob(), (k == set_len - 1), 1'b0, none);
      coins += set_len;
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for late extra words
    while (expected_sets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_sets.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Compare each result word with the oldest expected set
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (expected_sets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: tail %h seen %0d too_many %0b",
                   result.tail_prob, result.coins_seen, result.too_many);
      end else begin
        want = expected_sets.pop_front();
        if (result.tail_prob !== want.tail_prob || result.coins_seen !== want.coins_seen ||
            result.too_many !== want.too_many) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: tail exp %h got %h, seen exp %0d got %0d, too_many exp %0b got %0b",
                     want.tail_prob, result.tail_prob, want.coins_seen, result.coins_seen,
                     want.too_many, result.too_many);
        end
      end
    end
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

### sim.f
src/chmp_pkg.sv
src/chmp_ram.sv
src/chmp_mac.sv
src/coin_heads_majority_probability_unit.sv
tb/sv/coin_heads_majority_probability_unit_tb.sv
